// File: rtl/core/assert_macros.svh
// Assertion macros shared by the address set table RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)

`endif

`endif

// File: rtl/core/bast_pkg.sv
// Types and constants of the bounded address set table.
// No dependencies; used by bast_cell and bounded_address_set_table.
`timescale 1ns / 1ps
`default_nettype none

package bast_pkg;

  localparam int unsigned KeyW          = 48;
  localparam int unsigned IndexW        = 5;
  localparam int unsigned CountOutW     = 6;
  localparam int unsigned MaxEntriesW   = 6;
  localparam int unsigned DefCapacity   = 32;
  localparam logic [MaxEntriesW-1:0] MaxEntriesReset = 6'd32;

  typedef enum logic [1:0] {
    ActAdd    = 2'd0,
    ActRemove = 2'd1,
    ActGet    = 2'd2
  } action_e;

  typedef struct packed {
    action_e           action;
    logic [31:0]       ip_address;
    logic [15:0]       port_number;
    logic [IndexW-1:0] index;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [31:0]          entry_ip;
    logic [15:0]          entry_port;
    logic [CountOutW-1:0] count;
  } rsp_t;

  // ripple word handed from one cell to the next
  typedef struct packed {
    logic            hit_seen;
    logic            get_hit;
    logic [KeyW-1:0] rd_data;
  } chain_t;

  // write control broadcast to every cell
  typedef struct packed {
    logic append;
    logic shift;
  } ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/bast_cell.sv
// One table cell: holds a single entry and passes match and read words along the row.
// Depends on bast_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bast_cell
  import bast_pkg::*;
#(
  parameter int unsigned Pos    = 0,
  parameter int unsigned CountW = 6
) (
  input  wire logic              clk_i,
  input  wire ctl_t              ctl_i,
  input  wire logic [KeyW-1:0]   key_i,
  input  wire logic [IndexW-1:0] index_i,
  input  wire logic [CountW-1:0] count_i,
  input  wire logic [KeyW-1:0]   nxt_data_i,
  output logic      [KeyW-1:0]   data_o,
  input  wire chain_t            chain_i,
  output chain_t                 chain_o
);

  localparam logic [31:0] PosW = 32'(Pos);

  logic [KeyW-1:0] data_q;
  logic [31:0]     count_w;
  logic            valid;
  logic            hit;
  logic            sel;
  logic            tail;

  assign count_w = 32'(count_i);
  assign valid   = count_w > PosW;
  assign tail    = count_w == PosW;
  assign hit     = valid && (data_q == key_i);
  assign sel     = valid && (32'(index_i) == PosW);

  always_comb begin
    chain_o.hit_seen = chain_i.hit_seen | hit;
    chain_o.get_hit  = chain_i.get_hit | sel;
    chain_o.rd_data  = chain_i.rd_data | (sel ? data_q : '0);
  end

  // close the gap on remove, take the new key at the tail on add
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift && chain_o.hit_seen) begin
      data_q <= nxt_data_i;
    end else if (ctl_i.append && tail) begin
      data_q <= key_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: rtl/core/bounded_address_set_table.sv
// Bounded, ordered, duplicate-free table of address and port entries.
// Registered in order: busy_q, then rsp_q together with done_o; a new start is taken only when not busy.
// The match compare across all cells and the ripple through the cell row are combinational.
// Reset clears the entry count and sets max_entries to 32; no clearing pass.
// The receiver cannot stall: done_o lasts one cycle.
// Depends on bast_pkg, bast_cell and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bounded_address_set_table
  import bast_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);
  localparam int unsigned LimW   = (CountW > MaxEntriesW) ? CountW : MaxEntriesW;
  localparam logic [LimW-1:0] CapL = LimW'(CAPACITY);

  logic                   busy_q;
  logic                   done_q;
  logic [CountW-1:0]      count_q, count_d;
  logic [MaxEntriesW-1:0] max_q;
  req_t                   req_q;
  rsp_t                   rsp_q, rsp_d;
  ctl_t                   ctl;
  logic [KeyW-1:0]        key;
  logic [KeyW-1:0]        data [CAPACITY];
  chain_t                 chain [CAPACITY+1];
  logic [LimW-1:0]        max_l, limit, count_l, count_dl;
  logic                   room;
  logic                   found;
  logic                   cfg_wr;

  assign key = {req_q.ip_address, req_q.port_number};

  assign chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KeyW-1:0] nxt;
    if (i + 1 < CAPACITY) begin : g_mid
      assign nxt = data[i+1];
    end else begin : g_last
      assign nxt = data[i];
    end
    bast_cell #(
      .Pos    (i),
      .CountW (CountW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .key_i      (key),
      .index_i    (req_q.index),
      .count_i    (count_q),
      .nxt_data_i (nxt),
      .data_o     (data[i]),
      .chain_i    (chain[i]),
      .chain_o    (chain[i+1])
    );
  end

  assign found   = chain[CAPACITY].hit_seen;
  assign max_l   = LimW'(max_q);
  assign limit   = (max_l < CapL) ? max_l : CapL;
  assign count_l = LimW'(count_q);
  assign room    = count_l < limit;

  always_comb begin
    ctl     = '0;
    count_d = count_q;
    rsp_d   = '0;
    case (req_q.action)
      ActAdd: begin
        rsp_d.ok   = found || room;
        ctl.append = busy_q && !found && room;
        if (!found && room) begin
          count_d = count_q + CountW'(1);
        end
      end
      ActRemove: begin
        rsp_d.ok  = found;
        ctl.shift = busy_q && found;
        if (found) begin
          count_d = count_q - CountW'(1);
        end
      end
      ActGet: begin
        rsp_d.ok         = chain[CAPACITY].get_hit;
        rsp_d.entry_ip   = chain[CAPACITY].rd_data[47:16];
        rsp_d.entry_port = chain[CAPACITY].rd_data[15:0];
      end
      default: begin
        rsp_d.ok = 1'b0;
      end
    endcase
    count_dl    = LimW'(count_d);
    rsp_d.count = count_dl[CountOutW-1:0];
  end

  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
      max_q   <= MaxEntriesReset;
    end else begin
      done_q <= busy_q;
      if (busy_q) begin
        busy_q  <= 1'b0;
        count_q <= count_d;
      end else if (start) begin
        busy_q <= 1'b1;
      end
      if (cfg_wr) begin
        max_q <= pwdata[MaxEntriesW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      req_q <= req_i;
    end
    if (busy_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(max_q);

  `ASSERT_NEVER(a_done_while_busy, clk_i, rst_ni, done_q && busy_q, "result during work")
  `ASSERT_HOLDS(a_start_done, clk_i, rst_ni, (start && !busy_q) |=> ##1 done_q, "result missing")
  `ASSERT_HOLDS(a_count_idle, clk_i, rst_ni, !busy_q |=> $stable(count_q), "count moved idle")
  `ASSERT_NEVER(a_count_cap, clk_i, rst_ni, 32'(count_q) > 32'(CAPACITY), "count above capacity")

endmodule

`default_nettype wire
